// ===== rtl/rml_pkg.sv =====
// Shared widths, the distance lookup table and lane record type for the min/max localizer.
package rml_pkg;

    // Number of anchors carried by one input beat and the lanes that are built
    localparam int ANCHOR_SLOTS = 4;
    localparam int ANCHOR_COUNT = 4;
    localparam int FRAC_BITS    = 8;

    // Field widths
    localparam int RSSI_W  = 8;
    localparam int COORD_W = 12;
    localparam int POS_W   = 21;
    // Longest distance is below 512 m, so 9 integer bits
    localparam int DIST_W  = FRAC_BITS + 9;
    // Box edge: scaled coordinate plus or minus a distance, with headroom
    localparam int BOX_W   = COORD_W + FRAC_BITS + 2;
    localparam int SUM_W   = BOX_W + 1;

    localparam int CFG_INDEX_W = 3;
    localparam int IN_DATA_W   = ANCHOR_SLOTS * RSSI_W;
    localparam int OUT_DATA_W  = ((2 * POS_W + 7) / 8) * 8;

    // Register index decode: bit 0 selects the axis, upper bits the anchor
    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    // Q28 constants of the distance curve
    localparam longint unsigned ROOT_TEN_Q28 = 64'd292332370;
    localparam longint unsigned ONE_Q28      = 64'd268435456;
    localparam int              Q28_SHIFT    = 28;

    // Reciprocal of ten for operands below 2^32: (t * RECIP_TEN) >> RECIP_TEN_SHIFT
    localparam longint unsigned RECIP_TEN       = 64'hCCCCCCCD;
    localparam int              RECIP_TEN_SHIFT = 35;

    localparam int TABLE_DEPTH = 2 ** RSSI_W;

    typedef logic [DIST_W-1:0] dist_table_t [TABLE_DEPTH];

    // One lane's findings for one beat
    typedef struct packed {
        logic                    present;
        logic signed [BOX_W-1:0] lo_x;
        logic signed [BOX_W-1:0] hi_x;
        logic signed [BOX_W-1:0] lo_y;
        logic signed [BOX_W-1:0] hi_y;
    } box_t;

    // Distance 10^((-59 - rssi)/27) in Q(FRAC_BITS), indexed by the raw reading code
    function automatic dist_table_t build_dist_table();
        dist_table_t       tbl;
        longint            rssi;
        longint            u;
        longint            q;
        longint            r;
        longint unsigned   m;
        longint unsigned   num;
        longint unsigned   t;
        longint unsigned   p_up;
        longint unsigned   p_dn;
        for (int code = 0; code < TABLE_DEPTH; code++) begin
            rssi = (code >= (TABLE_DEPTH >> 1)) ? longint'(code) - longint'(TABLE_DEPTH)
                                                : longint'(code);
            u = -59 - rssi + 189;
            // Split the exponent into decades and 27ths of a decade
            q = -7;
            r = u;
            while (r >= 27) begin
                r = r - 27;
                q = q + 1;
            end
            m = ONE_Q28;
            for (longint i = 0; i < r; i++) begin
                m = (m * ROOT_TEN_Q28 + (64'd1 << (Q28_SHIFT - 1))) >> Q28_SHIFT;
            end
            p_up = 64'd1;
            p_dn = 64'd1;
            for (longint i = 0; i < q; i++) begin
                p_up = p_up * 64'd10;
            end
            for (longint i = 0; i < -q; i++) begin
                p_dn = p_dn * 64'd10;
            end
            // Round half up, then strip the binary scale and each decade in turn
            num = m * p_up;
            t   = (num + (p_dn << (Q28_SHIFT - FRAC_BITS - 1))) >> (Q28_SHIFT - FRAC_BITS);
            for (longint i = 0; i < -q; i++) begin
                t = (t * RECIP_TEN) >> RECIP_TEN_SHIFT;
            end
            tbl[code] = DIST_W'(t);
        end
        return tbl;
    endfunction

    localparam dist_table_t DIST_TABLE = build_dist_table();

endpackage

// ===== rtl/rssi_minmax_localizer_unit.sv =====
// Top level of the min/max localizer: anchor registers, lanes, merge and flow control.
//
//  channel   | direction | beat contents
//  ----------+-----------+--------------------------------------------------------
//  s_axis    | in        | tdata: rssi_a[7:0], rssi_b[15:8], rssi_c[23:16], rssi_d[31:24]
//  m_axis    | out       | tdata: pos_x[20:0], pos_y[41:21], zero pad; tuser: pos_valid
//  cfg       | in        | cfg_index selects anchor0_x .. anchor3_y, cfg_wdata 12 bits
//
// One beat per cycle sustained while m_axis is ready; each beat passes the lane register,
// then the output register. Lanes run the distance table lookup in parallel.
// rst_n clears the anchor positions and the valid flags of both stages.
// A stall on m_axis holds the output register; the lane stage still fills if it is empty.
module rssi_minmax_localizer_unit
    import rml_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]     cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // rssi_a, rssi_b, rssi_c, rssi_d
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // pos_x, pos_y, zero pad
    output logic                   m_axis_tuser    // pos_valid
);

    logic signed [COORD_W-1:0] anchor_x_reg [ANCHOR_SLOTS];
    logic signed [COORD_W-1:0] anchor_y_reg [ANCHOR_SLOTS];
    logic                      lane_valid_reg, lane_valid_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      out_free;
    logic                      lane_load;
    logic                      merge_load;
    box_t                      boxes [ANCHOR_COUNT];
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic                      pos_valid;

    // Write anchor positions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ANCHOR_SLOTS; i++)
            begin
                anchor_x_reg[i] <= '0;
                anchor_y_reg[i] <= '0;
            end
        end
        else if (cfg_wen)
        begin
            if (cfg_index[0] == AXIS_X)
            begin
                anchor_x_reg[cfg_index[CFG_INDEX_W-1:1]] <= signed'(cfg_wdata);
            end
            else
            begin
                anchor_y_reg[cfg_index[CFG_INDEX_W-1:1]] <= signed'(cfg_wdata);
            end
        end
    end

    // Advance the two stages when the slot ahead frees up
    always_comb
    begin
        out_free        = !out_valid_reg || m_axis_tready;
        merge_load      = lane_valid_reg && out_free;
        s_axis_tready   = !lane_valid_reg || out_free;
        lane_load       = s_axis_tvalid && s_axis_tready;
        lane_valid_next = lane_load ? 1'b1 : (merge_load ? 1'b0 : lane_valid_reg);
        out_valid_next  = merge_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            lane_valid_reg <= lane_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // One lane per anchor
    for (genvar g = 0; g < ANCHOR_COUNT; g++)
    begin : g_lane
        rml_lane u_lane (
            .clk      (clk),
            .load     (lane_load),
            .rssi     (s_axis_tdata[g*RSSI_W +: RSSI_W]),
            .anchor_x (anchor_x_reg[g]),
            .anchor_y (anchor_y_reg[g]),
            .box      (boxes[g])
        );
    end

    rml_merge u_merge (
        .clk       (clk),
        .load      (merge_load),
        .boxes     (boxes),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_valid (pos_valid)
    );

    // Pack the result beat
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - 2 * POS_W){1'b0}}, pos_y, pos_x};
    assign m_axis_tuser  = pos_valid;

endmodule

// ===== rtl/rml_lane.sv =====
// One anchor lane: distance lookup and the anchor's square box, registered.
module rml_lane
    import rml_pkg::*;
(
    input  logic                      clk,
    input  logic                      load,
    input  logic        [RSSI_W-1:0]  rssi,
    input  logic signed [COORD_W-1:0] anchor_x,
    input  logic signed [COORD_W-1:0] anchor_y,
    output box_t                      box
);

    logic        [DIST_W-1:0] dist_q;
    logic signed [BOX_W-1:0]  dist_ext;
    logic signed [BOX_W-1:0]  cx;
    logic signed [BOX_W-1:0]  cy;
    box_t                     box_next;
    box_t                     box_reg;

    // Look up distance and scale anchor position to the fixed point grid
    always_comb
    begin
        dist_q   = DIST_TABLE[rssi];
        dist_ext = signed'({{(BOX_W - DIST_W){1'b0}}, dist_q});
        cx = signed'({{(BOX_W - COORD_W - FRAC_BITS){anchor_x[COORD_W-1]}},
                      anchor_x, {FRAC_BITS{1'b0}}});
        cy = signed'({{(BOX_W - COORD_W - FRAC_BITS){anchor_y[COORD_W-1]}},
                      anchor_y, {FRAC_BITS{1'b0}}});
        box_next.present = (rssi != '0);
        box_next.lo_x    = cx - dist_ext;
        box_next.hi_x    = cx + dist_ext;
        box_next.lo_y    = cy - dist_ext;
        box_next.hi_y    = cy + dist_ext;
    end

    // Hold the box while the next stage is stalled
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            box_reg <= box_next;
        end
    end

    assign box = box_reg;

endmodule

// ===== rtl/rml_merge.sv =====
// Merge stage: intersect lane boxes, take the midpoint, saturate, register the result.
module rml_merge
    import rml_pkg::*;
(
    input  logic                    clk,
    input  logic                    load,
    input  box_t                    boxes [ANCHOR_COUNT],
    output logic signed [POS_W-1:0] pos_x,
    output logic signed [POS_W-1:0] pos_y,
    output logic                    pos_valid
);

    localparam logic signed [BOX_W-1:0] POS_MAX_EXT = BOX_W'(2 ** (POS_W - 1) - 1);
    localparam logic signed [BOX_W-1:0] POS_MIN_EXT = -BOX_W'(2 ** (POS_W - 1));

    logic signed [POS_W-1:0] pos_x_next, pos_x_reg;
    logic signed [POS_W-1:0] pos_y_next, pos_y_reg;
    logic                    pos_valid_next, pos_valid_reg;

    function automatic logic signed [POS_W-1:0] mid_sat(
        input logic signed [BOX_W-1:0] lo,
        input logic signed [BOX_W-1:0] hi
    );
        logic signed [SUM_W-1:0] sum;
        logic signed [BOX_W-1:0] half;
        logic signed [POS_W-1:0] res;
        sum  = SUM_W'(lo) + SUM_W'(hi);
        half = BOX_W'(sum >>> 1);
        if (half > POS_MAX_EXT)
        begin
            res = POS_MAX_EXT[POS_W-1:0];
        end
        else if (half < POS_MIN_EXT)
        begin
            res = POS_MIN_EXT[POS_W-1:0];
        end
        else
        begin
            res = half[POS_W-1:0];
        end
        return res;
    endfunction

    // Keep the largest lower edge and the smallest upper edge of present lanes
    always_comb
    begin
        logic                    any;
        logic signed [BOX_W-1:0] lo_x, hi_x, lo_y, hi_y;
        any  = 1'b0;
        lo_x = '0;
        hi_x = '0;
        lo_y = '0;
        hi_y = '0;
        for (int i = 0; i < ANCHOR_COUNT; i++)
        begin
            if (boxes[i].present)
            begin
                if (!any || boxes[i].lo_x > lo_x)
                begin
                    lo_x = boxes[i].lo_x;
                end
                if (!any || boxes[i].hi_x < hi_x)
                begin
                    hi_x = boxes[i].hi_x;
                end
                if (!any || boxes[i].lo_y > lo_y)
                begin
                    lo_y = boxes[i].lo_y;
                end
                if (!any || boxes[i].hi_y < hi_y)
                begin
                    hi_y = boxes[i].hi_y;
                end
                any = 1'b1;
            end
        end
        pos_valid_next = any;
        pos_x_next     = any ? mid_sat(lo_x, hi_x) : '0;
        pos_y_next     = any ? mid_sat(lo_y, hi_y) : '0;
    end

    // Hold the result until the sink takes it
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            pos_valid_reg <= pos_valid_next;
        end
    end

    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign pos_valid = pos_valid_reg;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the min/max bounding-box localizer unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rml_pkg::*;

    // Register map of the anchor coordinate port
    typedef enum logic [CFG_INDEX_W-1:0] {
        ANCHOR0_X, ANCHOR0_Y, ANCHOR1_X, ANCHOR1_Y,
        ANCHOR2_X, ANCHOR2_Y, ANCHOR3_X, ANCHOR3_Y
    } anchor_reg_t;

    // One predicted position beat
    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic                    heard;
    } fix_t;

    localparam int PHASES        = 8;
    localparam int PHASE_BEATS   = 235;
    localparam int HOLD_OFF_LEN  = 300;
    localparam longint POS_MAX   = (longint'(1) << (POS_W - 1)) - 1;
    localparam longint POS_MIN   = -(longint'(1) << (POS_W - 1));

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wen = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [COORD_W-1:0]     cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;   // rssi_a, rssi_b, rssi_c, rssi_d
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;        // pos_x, pos_y, zero pad
    logic                   m_axis_tuser;        // pos_valid

    // Predictor copy of the anchor registers and the layout to load next
    logic signed [COORD_W-1:0] anchor_coord [ANCHOR_SLOTS][2];
    logic signed [COORD_W-1:0] layout [2 * ANCHOR_SLOTS];

    logic [IN_DATA_W-1:0] rssi_beats [$];
    fix_t                 expected_fixes [$];

    int send_idle_max = 9;
    int recv_idle_max = 9;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;

    int mismatch_count = 0;
    int beats_in = 0;
    int fixes_checked = 0;
    int unheard_fixes = 0;
    int layouts_loaded = 0;

    rssi_minmax_localizer_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    // Distance 10^((-59 - rssi)/27) in Q(FRAC_BITS), rounded half up
    function automatic longint range_from_rssi(input logic signed [RSSI_W-1:0] rssi);
        longint          excess;
        int              decade;
        int              rem;
        longint unsigned mant;
        longint unsigned num;
        longint unsigned den;
        excess = 130 - longint'(rssi);
        decade = int'(excess / 27) - 7;
        rem    = int'(excess % 27);
        mant   = ONE_Q28;
        for (int i = 0; i < rem; i++)
            mant = (mant * ROOT_TEN_Q28 + (64'd1 << (Q28_SHIFT - 1))) >> Q28_SHIFT;
        num = mant;
        den = 64'd1;
        for (int i = 0; i < decade; i++)
            num = num * 64'd10;
        for (int i = 0; i < -decade; i++)
            den = den * 64'd10;
        den = den << (Q28_SHIFT - FRAC_BITS);
        return longint'((num + den / 64'd2) / den);
    endfunction

    function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
        if (v > POS_MAX)
            return POS_W'(POS_MAX);
        if (v < POS_MIN)
            return POS_W'(POS_MIN);
        return POS_W'(v);
    endfunction

    // Intersect the boxes of all heard anchors and take the midpoint
    function automatic fix_t predict_fix(input logic [IN_DATA_W-1:0] beat);
        fix_t                      fix;
        longint                    lo [2];
        longint                    hi [2];
        longint                    radius;
        longint                    center;
        longint                    low_side;
        longint                    high_side;
        logic signed [RSSI_W-1:0]  reading;
        bit                        heard;
        heard = 1'b0;
        lo[0] = 0;
        lo[1] = 0;
        hi[0] = 0;
        hi[1] = 0;
        for (int a = 0; a < ANCHOR_COUNT; a++) begin
            reading = beat[a*RSSI_W +: RSSI_W];
            if (reading != 0) begin
                radius = range_from_rssi(reading);
                for (int ax = 0; ax < 2; ax++) begin
                    center    = longint'(anchor_coord[a][ax]) * (longint'(1) << FRAC_BITS);
                    low_side  = center - radius;
                    high_side = center + radius;
                    if (!heard || low_side > lo[ax])
                        lo[ax] = low_side;
                    if (!heard || high_side < hi[ax])
                        hi[ax] = high_side;
                end
                heard = 1'b1;
            end
        end
        fix.heard = heard;
        if (heard) begin
            fix.x = clamp_pos((lo[0] + hi[0]) >>> 1);
            fix.y = clamp_pos((lo[1] + hi[1]) >>> 1);
        end else begin
            fix.x = '0;
            fix.y = '0;
        end
        return fix;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_rssi(input int a, input int b,
                                                       input int c, input int d);
        return {RSSI_W'(d), RSSI_W'(c), RSSI_W'(b), RSSI_W'(a)};
    endfunction

    // Mostly realistic readings, some absent, some positive or at the extremes
    function automatic int draw_reading();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            return 0;
        if (pick < 80)
            return -int'($urandom_range(1, 128));
        if (pick < 90)
            return -int'($urandom_range(45, 70));
        if (pick < 95)
            return int'($urandom_range(1, 127));
        case ($urandom_range(0, 3))
            0:       return -128;
            1:       return -1;
            2:       return 1;
            default: return 127;
        endcase
    endfunction

    function automatic logic [IN_DATA_W-1:0] draw_beat();
        if ($urandom_range(0, 99) < 3)
            return '0;
        return pack_rssi(draw_reading(), draw_reading(), draw_reading(), draw_reading());
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] MISMATCH %s on position beat %0d: expected %0d, got %0d",
                     $realtime, what, fixes_checked, want, got);
    endtask

    // Write all anchor registers from the layout array, one per cycle
    task automatic program_layout();
        anchor_reg_t idx;
        for (int i = 0; i < 2 * ANCHOR_SLOTS; i++) begin
            idx = anchor_reg_t'(i);
            @(posedge clk);
            cfg_wen   <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= layout[i];
            anchor_coord[i / 2][i % 2] = layout[i];
        end
        @(posedge clk);
        cfg_wen <= 1'b0;
        layouts_loaded++;
    endtask

    // Wait until every beat is taken and every position has come back
    task automatic wait_until_drained();
        while (rssi_beats.size() != 0)
            @(posedge clk);
        // let the last popped beat show up on tvalid before looking at it
        @(posedge clk);
        while (s_axis_tvalid || expected_fixes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Input driver: present queued beats, hold until taken, then idle
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            send_gap      <= 0;
        end else if (s_axis_tvalid && !s_axis_tready) begin
            // hold the current beat
        end else if (send_gap != 0) begin
            s_axis_tvalid <= 1'b0;
            send_gap      <= send_gap - 1;
        end else if (rssi_beats.size() != 0) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= rssi_beats.pop_front();
            send_gap      <= $urandom_range(0, send_idle_max);
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Output receiver: random stall after each beat, long hold-off on request
    always @(posedge clk or negedge rst_n) begin : receiver
        int gap;
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            recv_gap      <= 0;
            hold_left     <= 0;
            hold_ack      <= 0;
        end else if (hold_ack != hold_req) begin
            hold_ack      <= hold_req;
            hold_left     <= HOLD_OFF_LEN;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= (hold_left == 1);
        end else if (m_axis_tready && m_axis_tvalid) begin
            gap           = $urandom_range(0, recv_idle_max);
            recv_gap      <= gap;
            m_axis_tready <= (gap == 0);
        end else if (recv_gap != 0) begin
            recv_gap      <= recv_gap - 1;
            m_axis_tready <= (recv_gap == 1);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Predict on every accepted input beat, check every accepted output beat
    always @(posedge clk) begin : scoreboard
        fix_t                    want;
        logic signed [POS_W-1:0] got_x;
        logic signed [POS_W-1:0] got_y;
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_fixes.push_back(predict_fix(s_axis_tdata));
                beats_in++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got_x = m_axis_tdata[POS_W-1:0];
                got_y = m_axis_tdata[2*POS_W-1:POS_W];
                if (expected_fixes.size() == 0) begin
                    report_mismatch("beat with no position pending, pos_x", 0, got_x);
                end else begin
                    want = expected_fixes.pop_front();
                    if (got_x !== want.x)
                        report_mismatch("pos_x", want.x, got_x);
                    if (got_y !== want.y)
                        report_mismatch("pos_y", want.y, got_y);
                    if (m_axis_tuser !== want.heard)
                        report_mismatch("pos_valid", want.heard, m_axis_tuser);
                    if (!want.heard)
                        unheard_fixes++;
                end
                fixes_checked++;
            end
        end
    end

    // Stimulus sequence: directed beats, then random phases over several layouts
    initial begin : stimulus
        for (int a = 0; a < ANCHOR_SLOTS; a++) begin
            anchor_coord[a][0] = '0;
            anchor_coord[a][1] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: anchors on a 20 m square, so short ranges leave an empty box
        layout = '{12'sd0, 12'sd0, 12'sd20, 12'sd0, 12'sd0, 12'sd20, 12'sd20, 12'sd20};
        program_layout();
        rssi_beats.push_back(pack_rssi(0, 0, 0, 0));
        rssi_beats.push_back(pack_rssi(-128, 0, 0, 0));
        rssi_beats.push_back(pack_rssi(0, -128, 0, 0));
        rssi_beats.push_back(pack_rssi(0, 0, -128, 0));
        rssi_beats.push_back(pack_rssi(0, 0, 0, -128));
        rssi_beats.push_back(pack_rssi(-59, -59, -59, -59));
        rssi_beats.push_back(pack_rssi(-1, -1, -1, -1));
        rssi_beats.push_back(pack_rssi(127, 127, 127, 127));
        rssi_beats.push_back(pack_rssi(1, 0, 0, 0));
        rssi_beats.push_back(pack_rssi(-128, -128, -128, -128));
        rssi_beats.push_back(pack_rssi(-86, -113, -60, -58));
        rssi_beats.push_back(pack_rssi(-128, -1, 0, 0));
        rssi_beats.push_back(pack_rssi(0, 0, -45, -100));
        rssi_beats.push_back(pack_rssi(-1, 127, -128, 1));
        rssi_beats.push_back(pack_rssi(-70, -70, -70, -70));
        rssi_beats.push_back(pack_rssi(0, -1, 0, 127));
        rssi_beats.push_back(pack_rssi(-100, -100, -100, -100));
        wait_until_drained();

        for (int phase = 0; phase < PHASES; phase++) begin
            // Pick the anchor layout: extremes first, then realistic and random spreads
            for (int i = 0; i < 2 * ANCHOR_SLOTS; i++) begin
                case (phase)
                    0:       layout[i] = (((i / 2) >> (i % 2)) & 1) ? 12'sd2047 : -12'sd2048;
                    1:       layout[i] = 12'sd2047;
                    2:       layout[i] = -12'sd2048;
                    3:       layout[i] = '0;
                    7:       layout[i] = COORD_W'($urandom_range(0, 4095));
                    default: layout[i] = COORD_W'(int'($urandom_range(0, 100)) - 50);
                endcase
            end
            program_layout();

            send_idle_max = (phase == 1 || phase == 4 || phase == 6) ? 0 : 9;
            recv_idle_max = (phase == 2 || phase == 4 || phase == 7) ? 0 : 9;
            for (int n = 0; n < PHASE_BEATS; n++)
                rssi_beats.push_back(draw_beat());
            // Back-pressure: stall the output long enough to fill the pipeline
            if (phase == 2 || phase == 5)
                hold_req++;
            wait_until_drained();
        end

        repeat (8) @(posedge clk);
        $display("Checked %0d positions from %0d rssi beats over %0d anchor layouts",
                 fixes_checked, beats_in, layouts_loaded);
        $display("%0d beats had no anchor heard; %0d mismatches", unheard_fixes, mismatch_count);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #(10_000_000);
        $display("Timeout with %0d positions outstanding", expected_fixes.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
